>>> rtl/akm_pkg.sv
// Shared types, constants and keyword table for the acknowledgement keyword matcher.
package akm_pkg;

    localparam int NUM_KW      = 41;
    localparam int CHUNK_FIRST = 10;
    localparam int CHUNK_KEYS  = 3;

    // One input transaction.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } akm_in_t;

    // One result transaction.
    typedef struct packed {
        logic              found;
        logic [5:0]        keyword_index;
        logic              chunk_valid;
        logic signed [7:0] chunk_id;
    } akm_out_t;

    // Token that moves down the cell chain, one cell per cycle while advance is high.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       active;      // byte takes part in matching (before end of string)
        logic       last;        // final byte of the buffer, carries the result
        logic       found;
        logic [5:0] hit;
        logic       chunk_valid;
        logic [7:0] c0;
        logic [7:0] c1;
    } akm_token_t;

    // Keywords, already lower case, right-justified in 7 bytes.
    function automatic logic [55:0] kw_str(input int k);
        logic [55:0] s;
        begin
            case (k)
                0:       s = "sotx";
                1:       s = "dfrm";
                2:       s = "dxxm";
                3:       s = "dorm";
                4:       s = "mfld";
                5:       s = "dxbl";
                6:       s = "ruphs";
                7:       s = "ruph";
                8:       s = "difwi";
                9:       s = "dcfi00";
                10:      s = "rdy$";
                11:      s = "$ack";
                12:      s = "nack";
                13:      s = "eoio";
                14:      s = "er40";
                15:      s = "osip sz";
                16:      s = "rosip";
                17:      s = "done";
                18:      s = "rimg";
                19:      s = "eoiu";
                20:      s = "hlt$";
                21:      s = "er00";
                22:      s = "hlt0";
                23:      s = "er01";
                24:      s = "er02";
                25:      s = "er03";
                26:      s = "er04";
                27:      s = "er10";
                28:      s = "er11";
                29:      s = "er12";
                30:      s = "er13";
                31:      s = "er20";
                32:      s = "er21";
                33:      s = "er22";
                34:      s = "er25";
                35:      s = "errr";
                36:      s = "erb0";
                37:      s = "erb1";
                38:      s = "rtbd";
                39:      s = "dcsdb";
                40:      s = "ucsdb";
                default: s = '0;
            endcase
            return s;
        end
    endfunction

    function automatic int kw_len(input int k);
        logic [55:0] s;
        int          n;
        begin
            s = kw_str(k);
            n = 0;
            for (int i = 0; i < 7; i++) begin
                if (s[8*i +: 8] != 8'd0) begin
                    n = i + 1;
                end
            end
            return n;
        end
    endfunction

    // Character p of keyword k at byte p; unused positions are zero.
    function automatic logic [7:0][7:0] kw_chars(input int k);
        logic [55:0]     s;
        logic [7:0][7:0] c;
        int              n;
        begin
            s = kw_str(k);
            n = kw_len(k);
            c = '0;
            for (int i = 0; i < n; i++) begin
                c[i] = s[8*(n-1-i) +: 8];
            end
            return c;
        end
    endfunction

endpackage

>>> rtl/akm_cell.sv
// One keyword matcher cell of the chain: progress, seen flag, chunk capture, result pickup.
module akm_cell #(
    parameter int KW_INDEX = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [5:0]          start_keyword,
    input  akm_pkg::akm_token_t tok_in,
    output akm_pkg::akm_token_t tok_out
);

    localparam logic [7:0][7:0] CHARS    = akm_pkg::kw_chars(KW_INDEX);
    localparam logic [2:0]      LEN      = 3'(akm_pkg::kw_len(KW_INDEX));
    localparam logic [2:0]      LAST_POS = 3'(akm_pkg::kw_len(KW_INDEX) - 1);
    localparam logic [5:0]      IDX      = 6'(KW_INDEX);
    localparam logic            IS_CHUNK = (KW_INDEX >= akm_pkg::CHUNK_FIRST) &&
        (KW_INDEX < akm_pkg::CHUNK_FIRST + akm_pkg::CHUNK_KEYS);

    logic [2:0]          prog_reg, prog_next;
    logic                seen_reg, seen_next;
    logic [1:0]          cnt_reg, cnt_next;
    logic [7:0]          ch0_reg, ch0_next;
    logic [7:0]          ch1_reg, ch1_next;
    akm_pkg::akm_token_t tok_reg, tok_next;

    logic [2:0] prog_upd, p;
    logic       seen_upd;
    logic [1:0] cnt_upd;
    logic [7:0] ch0_upd, ch1_upd;
    logic [7:0] fb;

    always_comb
    begin
        fb       = (tok_in.data >= 8'h41 && tok_in.data <= 8'h5A) ?
                   tok_in.data + 8'd32 : tok_in.data;
        prog_upd = prog_reg;
        seen_upd = seen_reg;
        cnt_upd  = cnt_reg;
        ch0_upd  = ch0_reg;
        ch1_upd  = ch1_reg;
        p        = prog_reg;

        if (tok_in.active)
        begin
            // chunk bytes follow a completed match, checked against the old seen flag
            if (IS_CHUNK && seen_reg && cnt_reg < 2'd2)
            begin
                if (cnt_reg == 2'd0)
                begin
                    ch0_upd = tok_in.data;
                end
                else
                begin
                    ch1_upd = tok_in.data;
                end
                cnt_upd = cnt_reg + 2'd1;
            end
            if (!seen_reg)
            begin
                if (p >= LEN)
                begin
                    p = 3'd0;
                end
                // mismatch: restart and test the same byte against the first char
                if (fb != CHARS[p])
                begin
                    p = 3'd0;
                end
                if (fb == CHARS[p])
                begin
                    if (p == LAST_POS)
                    begin
                        seen_upd = 1'b1;
                        p        = 3'd0;
                    end
                    else
                    begin
                        p = p + 3'd1;
                    end
                end
                prog_upd = p;
            end
        end

        // first eligible seen keyword down the chain is the lowest index
        tok_next = tok_in;
        if (tok_in.valid && tok_in.last && !tok_in.found && seen_upd &&
            IDX >= start_keyword)
        begin
            tok_next.found       = 1'b1;
            tok_next.hit         = IDX;
            tok_next.chunk_valid = IS_CHUNK;
            tok_next.c0          = (IS_CHUNK && cnt_upd > 2'd0) ? ch0_upd : 8'd0;
            tok_next.c1          = (IS_CHUNK && cnt_upd > 2'd1) ? ch1_upd : 8'd0;
        end

        prog_next = prog_reg;
        seen_next = seen_reg;
        cnt_next  = cnt_reg;
        ch0_next  = ch0_reg;
        ch1_next  = ch1_reg;
        if (advance && tok_in.valid)
        begin
            ch0_next = ch0_upd;
            ch1_next = ch1_upd;
            if (tok_in.last)
            begin
                prog_next = 3'd0;
                seen_next = 1'b0;
                cnt_next  = 2'd0;
            end
            else
            begin
                prog_next = prog_upd;
                seen_next = seen_upd;
                cnt_next  = cnt_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prog_reg <= 3'd0;
            seen_reg <= 1'b0;
            cnt_reg  <= 2'd0;
            tok_reg  <= '0;
        end
        else
        begin
            prog_reg <= prog_next;
            seen_reg <= seen_next;
            cnt_reg  <= cnt_next;
            if (advance)
            begin
                tok_reg <= tok_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ch0_reg <= ch0_next;
        ch1_reg <= ch1_next;
    end

    assign tok_out = tok_reg;

endmodule

>>> rtl/akm_result.sv
// Chain tail: chunk number parse, output register and chain stall control.
module akm_result (
    input  logic                clk,
    input  logic                rst_n,
    input  akm_pkg::akm_token_t tok_in,
    output logic                advance,
    output logic                out_valid,
    input  logic                out_ready,
    output akm_pkg::akm_out_t   out_data
);

    logic              out_valid_reg, out_valid_next;
    akm_pkg::akm_out_t out_reg, out_next;
    logic              tail_result;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    // atoi over two bytes: optional blank, optional sign, up to two digits
    function automatic logic [7:0] parse_two(input logic [7:0] c0, input logic [7:0] c1);
        logic [7:0] d0, d1, r;
        begin
            d0 = c0 - 8'h30;
            d1 = c1 - 8'h30;
            r  = 8'd0;
            if (is_blank(c0))
            begin
                r = is_digit(c1) ? d1 : 8'd0;
            end
            else if (c0 == 8'h2B || c0 == 8'h2D)
            begin
                if (is_digit(c1))
                begin
                    r = (c0 == 8'h2D) ? 8'd0 - d1 : d1;
                end
            end
            else if (is_digit(c0))
            begin
                r = is_digit(c1) ? 8'(d0 * 8'd10) + d1 : d0;
            end
            return r;
        end
    endfunction

    assign tail_result = tok_in.valid && tok_in.last;
    assign advance     = !(tail_result && out_valid_reg && !out_ready);

    always_comb
    begin
        out_next.found         = tok_in.found;
        out_next.keyword_index = tok_in.hit;
        out_next.chunk_valid   = tok_in.chunk_valid;
        out_next.chunk_id      = tok_in.chunk_valid ?
                                 $signed(parse_two(tok_in.c0, tok_in.c1)) : 8'sd0;

        out_valid_next = out_valid_reg;
        if (tail_result && advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tail_result && advance)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

>>> rtl/ack_keyword_matcher_unit.sv
// Top level: byte-serial case-insensitive keyword matcher built as a chain of 41 cells.
//
// Usage:
//   in channel  (in_valid/in_ready/in_data): one reply byte per transaction, with
//     a last flag on the final byte of the buffer. A zero byte ends the string;
//     later bytes of the same buffer are ignored but still accepted.
//   out channel (out_valid/out_ready/out_data): one transaction per buffer,
//     produced by the byte that carries last; other bytes produce nothing.
//   cfg_we/cfg_wdata: writes start_keyword, the lowest keyword index searched.
//     Write only while no buffer is in flight.
// Throughput: one byte per clock while the chain is not stalled. Each byte walks
//   down the chain of 41 matcher cells, one registered cell per cycle, so the cells
//   work on 41 different bytes at once.
// Result path: cell 0 registers the last byte on its accepting edge, the byte
//   then passes 40 more cells, and the output register that holds the chunk
//   parse raises out_valid.
// Stall: if a result waits in the output register and out_ready is low when
//   the next result reaches the chain tail, the whole chain freezes and
//   in_ready drops until the receiver takes the waiting transaction.
// Reset: clears all match progress, seen flags, the end-of-string flag, the
//   output register valid, and sets start_keyword to 0.
module ack_keyword_matcher_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  akm_pkg::akm_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output akm_pkg::akm_out_t out_data,
    input  logic              cfg_we,
    input  logic [5:0]        cfg_wdata
);

    logic [5:0]          start_keyword_reg, start_keyword_next;
    logic                string_ended_reg, string_ended_next;
    logic                advance;
    logic                in_accept;
    akm_pkg::akm_token_t chain [akm_pkg::NUM_KW+1];

    assign in_ready  = advance;
    assign in_accept = in_valid && advance;

    // Head of chain: decide here whether the byte still belongs to the string.
    always_comb
    begin
        chain[0]             = '0;
        chain[0].valid       = in_valid;
        chain[0].data        = in_data.data_byte;
        chain[0].last        = in_data.last;
        chain[0].active      = in_valid && !string_ended_reg &&
                               (in_data.data_byte != 8'd0);

        string_ended_next = string_ended_reg;
        if (in_accept)
        begin
            if (in_data.last)
            begin
                string_ended_next = 1'b0;      // new buffer starts after last
            end
            else if (in_data.data_byte == 8'd0)
            begin
                string_ended_next = 1'b1;
            end
        end

        start_keyword_next = cfg_we ? cfg_wdata : start_keyword_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_keyword_reg <= 6'd0;
            string_ended_reg  <= 1'b0;
        end
        else
        begin
            start_keyword_reg <= start_keyword_next;
            string_ended_reg  <= string_ended_next;
        end
    end

    // Matcher cells, lowest keyword index first so the first hit wins.
    for (genvar k = 0; k < akm_pkg::NUM_KW; k++)
    begin : g_cell
        akm_cell #(
            .KW_INDEX (k)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .advance       (advance),
            .start_keyword (start_keyword_reg),
            .tok_in        (chain[k]),
            .tok_out       (chain[k+1])
        );
    end

    akm_result u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_in    (chain[akm_pkg::NUM_KW]),
        .advance   (advance),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

`ifndef SYNTHESIS
    // Input side only backs up behind a result the receiver has not taken.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("in_ready low without a blocked result");

    // A reported keyword respects the start register and the keyword range.
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.found) |->
        (out_data.keyword_index >= start_keyword_reg &&
         out_data.keyword_index < 6'(akm_pkg::NUM_KW)))
        else $error("keyword index out of range");

    // Chunk number only for the chunk keywords.
    a_chunk_kw: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.chunk_valid) |->
        (out_data.found && out_data.keyword_index >= 6'd10 &&
         out_data.keyword_index <= 6'd12))
        else $error("chunk_valid on a non-chunk keyword");

    // No match means all other result fields are zero.
    a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.found) |->
        (out_data.keyword_index == 6'd0 && !out_data.chunk_valid &&
         out_data.chunk_id == 8'sd0))
        else $error("fields set on a miss");
`endif

endmodule
